// ===== hw/rtl/zone_bitmap_allocator_core_macros.svh =====
// Assertion macros for the zone bitmap allocator.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ZONE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`define ZONE_BITMAP_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ZBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zba: same-cycle check failed");
`define ZBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zba: next-cycle check failed");
`else
`define ZBA_ASSERT_NOW(lbl, ante, cons)
`define ZBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/zba_pkg.sv =====
package zba_pkg;

  localparam int MAP_WORDS = 256;
  localparam int WORD_BITS = 16;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CAPACITY  = MAP_WORDS * WORD_BITS;
  localparam int ZBIT_W    = ADDR_W + BIT_W;     // bit number inside the map
  localparam int CAP_W     = $clog2(CAPACITY + 1);
  localparam int ZONE_W    = 20;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_LOAD  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREE_IDLE = 2'd2,
    ST_FREE_OOR  = 2'd3
  } status_e;

  typedef enum logic {
    CFG_FIRST_DATA_ZONE = 1'b0,
    CFG_ZONE_COUNT      = 1'b1
  } cfg_idx_e;

  // One write port and one read port of the bitmap memory.
  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } mem_req_t;

  // Returns {found, index} of the lowest clear bit of a word.
  function automatic logic [BIT_W:0] lowest_clear(logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] idx;
    logic             found;
    idx   = '0;
    found = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        idx   = BIT_W'(i);
        found = 1'b1;
      end
    end
    return {found, idx};
  endfunction

endpackage

// ===== hw/rtl/zone_bitmap_allocator_core.sv =====
// Next-fit zone allocator over a free-zone bitmap of 256 words of 16 bits, held in one
// synchronous RAM with one read and one write port. Bitmap bit b stands for zone
// first_data_zone - 1 + b; a set bit means used, and bit zero is never handed out. Each
// input word is a load (writes one bitmap word), an allocate (scans the words in a circle
// from the word that holds the origin and takes the lowest usable clear bit) or a free
// (clears a bit and lowers the search hint); each gives exactly one result word. Items are
// handled one at a time. A load or an unknown kind goes straight to its result, a free reads
// its word and then clears the bit (a zone out of range is ignored), and an allocate passes
// over up to 255 words before the hit or the end of the circle. The scan is bounded by
// the RAM read port, which delivers one word per cycle.
// A finished result sits in an output register, so the next item is taken while it waits.
// Configuration writes are always ready and must only be issued while the block is idle.
// After reset the bitmap reads as all free without any clearing pass.
`include "zone_bitmap_allocator_core_macros.svh"

module zone_bitmap_allocator_core
  import zba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Item channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [ZONE_W-1:0] zone_i,
  input  logic [7:0]        word_index_i,
  input  logic [15:0]       word_data_i,
  // Result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ZONE_W-1:0] result_zone_o,
  output logic [1:0]        status_o,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [ZONE_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ORIGIN,
    S_SCAN,
    S_FREE_CHK,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [ZONE_W-1:0]    fdz_q, zcnt_q;
  logic [CAP_W-1:0]     hint_q;
  logic [CAP_W-1:0]     lim_q;
  logic [1:0]           kind_q;
  logic [ZONE_W-1:0]    zone_q;
  logic [ADDR_W-1:0]    wrd_q;
  logic [ADDR_W-1:0]    cnt_q;
  logic [ZBIT_W-1:0]    bit_q;
  logic                 use_hint_q;
  logic [ZONE_W-1:0]    res_zone_q;
  status_e              res_st_q;
  logic                 out_valid_q;
  logic [ZONE_W-1:0]    out_zone_q;
  status_e              out_st_q;

  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rdata;

  logic                 in_acc;
  logic                 out_free;

  // Map size, clamped to [0, CAPACITY]; captured when an item is accepted.
  logic [ZONE_W+1:0]    lim_raw;
  logic [CAP_W-1:0]     lim_d;

  // Allocate origin and free bit, evaluated in S_ORIGIN.
  logic                 use_hint;
  logic [ZONE_W+1:0]    org_raw;
  logic                 org_ok;
  logic [ADDR_W-1:0]    start_w;
  logic [ZONE_W:0]      fbit;
  logic                 free_oor;

  // Word check during the scan.
  logic [WORD_BITS-1:0] scan_v;
  logic [BIT_W:0]       lc;
  logic [ZBIT_W-1:0]    hit_b;
  logic                 hit;
  logic [WORD_BITS-1:0] hit_mask;
  logic [WORD_BITS-1:0] free_mask;
  logic                 free_set;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    lim_raw = {2'b00, zcnt_q} + (ZONE_W + 2)'(1) - {2'b00, fdz_q};
    if (lim_raw[ZONE_W+1]) begin
      lim_d = '0;
    end else if (lim_raw > (ZONE_W + 2)'(CAPACITY)) begin
      lim_d = CAP_W'(CAPACITY);
    end else begin
      lim_d = lim_raw[CAP_W-1:0];
    end
  end

  always_comb begin
    use_hint = (zone_q == fdz_q);
    org_raw  = use_hint ? (ZONE_W + 2)'(hint_q)
                        : {2'b00, zone_q} + (ZONE_W + 2)'(1) - {2'b00, fdz_q};
    org_ok   = !org_raw[ZONE_W+1] && (org_raw < (ZONE_W + 2)'(lim_q));
    start_w  = org_ok ? org_raw[BIT_W +: ADDR_W] : '0;
    // A zone that passes the lower bound gives a non-negative bit number.
    fbit     = {1'b0, zone_q} + (ZONE_W + 1)'(1) - {1'b0, fdz_q};
    free_oor = (zone_q < fdz_q) || (zone_q >= zcnt_q) ||
               (fbit >= (ZONE_W + 1)'(CAPACITY));
  end

  always_comb begin
    scan_v    = rdata;
    // Bit zero of the map is the "no bit" code and is never allocated.
    if (wrd_q == '0) begin
      scan_v[0] = 1'b1;
    end
    lc        = lowest_clear(scan_v);
    hit_b     = {wrd_q, lc[BIT_W-1:0]};
    hit       = lc[BIT_W] && ((CAP_W)'(hit_b) < lim_q);
    hit_mask  = WORD_BITS'(1) << lc[BIT_W-1:0];
    free_mask = WORD_BITS'(1) << bit_q[BIT_W-1:0];
    free_set  = (rdata & free_mask) != '0;
  end

  // Memory port control.
  always_comb begin
    mem_req       = '0;
    mem_req.waddr = wrd_q;
    mem_req.raddr = wrd_q + ADDR_W'(1);
    case (state_q)
      S_IDLE: begin
        if (in_acc && kind_i == KIND_LOAD) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = word_index_i[ADDR_W-1:0];
          mem_req.wdata = word_data_i[WORD_BITS-1:0];
        end
      end
      S_ORIGIN: begin
        mem_req.raddr = (kind_q == KIND_ALLOC) ? start_w : fbit[BIT_W +: ADDR_W];
      end
      S_SCAN: begin
        if (hit) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rdata | hit_mask;
        end
      end
      S_FREE_CHK: begin
        mem_req.waddr = bit_q[BIT_W +: ADDR_W];
        if (free_set) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rdata & ~free_mask;
        end
      end
      default: begin
      end
    endcase
  end

  zba_bitmap_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdz_q  <= ZONE_W'(1);
      zcnt_q <= ZONE_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FIRST_DATA_ZONE: fdz_q  <= cfg_data_i;
        CFG_ZONE_COUNT:      zcnt_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, search hint and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hint_q      <= '0;
      lim_q       <= '0;
      kind_q      <= '0;
      zone_q      <= '0;
      wrd_q       <= '0;
      cnt_q       <= '0;
      bit_q       <= '0;
      use_hint_q  <= 1'b0;
      res_zone_q  <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_zone_q  <= '0;
      out_st_q    <= ST_OK;
    end else begin
      // In S_DONE the output register is reloaded below whenever it is free.
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            kind_q     <= kind_i;
            zone_q     <= zone_i;
            lim_q      <= lim_d;
            res_zone_q <= '0;
            res_st_q   <= ST_OK;
            if (kind_i == KIND_ALLOC || kind_i == KIND_FREE) begin
              state_q <= S_ORIGIN;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_ORIGIN: begin
          use_hint_q <= use_hint;
          wrd_q      <= start_w;
          cnt_q      <= '0;
          bit_q      <= fbit[ZBIT_W-1:0];
          if (kind_q == KIND_ALLOC) begin
            state_q <= S_SCAN;
          end else if (free_oor) begin
            res_st_q <= ST_FREE_OOR;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_FREE_CHK;
          end
        end
        S_SCAN: begin
          // The word for wrd_q arrives now; the next word's read is already issued.
          if (hit) begin
            res_zone_q <= fdz_q + ZONE_W'(hit_b) - ZONE_W'(1);
            if (use_hint_q) begin
              hint_q <= CAP_W'(hit_b);
            end
            state_q <= S_DONE;
          end else if (cnt_q == ADDR_W'(MAP_WORDS - 1)) begin
            res_st_q <= ST_NO_SPACE;
            state_q  <= S_DONE;
          end else begin
            wrd_q <= wrd_q + ADDR_W'(1);
            cnt_q <= cnt_q + ADDR_W'(1);
          end
        end
        S_FREE_CHK: begin
          if (!free_set) begin
            res_st_q <= ST_FREE_IDLE;
          end else if (CAP_W'(bit_q) < hint_q) begin
            hint_q <= CAP_W'(bit_q);
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_zone_q  <= res_zone_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_zone_o = out_zone_q;
  assign status_o      = out_st_q;

  // Every accepted item takes the block out of the idle state.
  `ZBA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, state_q != S_IDLE)
  // Only a successful allocate reports a nonzero zone.
  `ZBA_ASSERT_NOW(a_zone_only_on_ok, out_valid_o && status_o != ST_OK, result_zone_o == '0)
  // The bitmap is never written while a result waits to be handed over.
  `ZBA_ASSERT_NOW(a_no_write_in_done, state_q == S_DONE, !mem_req.we)
  // A scan never runs longer than one full circle of the map.
  `ZBA_ASSERT_NEXT(a_scan_bounded,
                   state_q == S_SCAN && cnt_q == ADDR_W'(MAP_WORDS - 1),
                   state_q == S_DONE)

endmodule

// ===== hw/rtl/zba_bitmap_store.sv =====
module zba_bitmap_store
  import zba_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mem_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvld_q;

  // Payload array with a registered read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  // A word that was never written since reset reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.raddr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ===== bench/zba_answer_checker.sv =====
// Watches the item, result and register channels of the zone allocator.
// Keeps its own copy of the bitmap, the search hint and the two registers,
// predicts the answer of every accepted item and compares answers in order.
module zba_answer_checker
  import zba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        kind_i,
  input  logic [ZONE_W-1:0] zone_i,
  input  logic [7:0]        word_index_i,
  input  logic [15:0]       word_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ZONE_W-1:0] result_zone_i,
  input  logic [1:0]        status_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_index_i,
  input  logic [ZONE_W-1:0] cfg_data_i,
  input  logic              drain_done_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                answers_o,
  output int                no_space_o
);

  localparam int HINT_W = 13;

  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    status_e           status;
  } zone_answer_t;

  logic [WORD_BITS-1:0] zone_map [MAP_WORDS];
  logic [HINT_W-1:0]    scan_hint;
  logic [ZONE_W-1:0]    first_zone;
  logic [ZONE_W-1:0]    zone_cnt;
  zone_answer_t         zone_answer_q [$];
  zone_answer_t         oldest_answer;
  zone_answer_t         next_answer;
  logic                 leftover_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] zba check: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic compute_zone_answer(input logic [1:0] kind, input logic [ZONE_W-1:0] zone,
                                     input logic [7:0] widx, input logic [15:0] wdat,
                                     output zone_answer_t ans);
    longint base, limit, origin, hit, bitn;
    int     w, sh;
    logic [WORD_BITS-1:0] v;
    ans.zone   = '0;
    ans.status = ST_OK;
    base  = longint'(first_zone) - 1;
    limit = longint'(zone_cnt) - longint'(first_zone) + 1;
    if (limit < 0) limit = 0;
    if (limit > CAPACITY) limit = CAPACITY;
    case (kind)
      KIND_ALLOC: begin
        origin = (zone == first_zone) ? longint'(scan_hint) : longint'(zone) - base;
        if (origin < 0 || origin >= limit) origin = 0;
        hit = -1;
        w   = int'(origin / WORD_BITS);
        for (int n = 0; n < MAP_WORDS && hit < 0; n++) begin
          v = zone_map[w];
          // Bit zero doubles as the "no zone" code and is never handed out.
          if (w == 0) v[0] = 1'b1;
          if (v != '1) begin
            sh = 0;
            while (v[sh]) sh++;
            if (longint'(w) * WORD_BITS + sh < limit) begin
              zone_map[w][sh] = 1'b1;
              hit = longint'(w) * WORD_BITS + sh;
            end
          end
          w = (w + 1) % MAP_WORDS;
        end
        if (hit < 0) begin
          ans.status = ST_NO_SPACE;
        end else begin
          if (zone == first_zone) scan_hint = HINT_W'(hit);
          ans.zone = ZONE_W'(base + hit);
        end
      end
      KIND_FREE: begin
        bitn = longint'(zone) - base;
        if (zone < first_zone || zone >= zone_cnt || bitn < 0 || bitn >= CAPACITY) begin
          ans.status = ST_FREE_OOR;
        end else begin
          w  = int'(bitn / WORD_BITS);
          sh = int'(bitn % WORD_BITS);
          if (!zone_map[w][sh]) begin
            ans.status = ST_FREE_IDLE;
          end else begin
            zone_map[w][sh] = 1'b0;
            if (bitn < longint'(scan_hint)) scan_hint = HINT_W'(bitn);
          end
        end
      end
      KIND_LOAD: begin
        zone_map[widx] = wdat;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (zone_map[i]) zone_map[i] = '0;
      scan_hint     = '0;
      first_zone    = ZONE_W'(1);
      zone_cnt      = ZONE_W'(4096);
      zone_answer_q.delete();
      leftover_seen = 1'b0;
      fail_count_o  = 0;
      answers_o     = 0;
      no_space_o    = 0;
    end else begin
      // Answers are compared before this edge's item is predicted, so an
      // answer can never be matched against the item accepted with it.
      if (out_valid_i && !out_stall_i) begin
        if (zone_answer_q.size() == 0) begin
          report_mismatch($sformatf("answer with nothing pending: zone %0d status %0d",
                                    result_zone_i, status_i));
        end else begin
          oldest_answer = zone_answer_q.pop_front();
          answers_o++;
          if (oldest_answer.status == ST_NO_SPACE) no_space_o++;
          if (result_zone_i !== oldest_answer.zone)
            report_mismatch($sformatf("result_zone %0d, predicted %0d",
                                      result_zone_i, oldest_answer.zone));
          if (status_i !== oldest_answer.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      status_i, oldest_answer.status));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIRST_DATA_ZONE: first_zone = cfg_data_i;
          CFG_ZONE_COUNT:      zone_cnt   = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        compute_zone_answer(kind_i, zone_i, word_index_i, word_data_i, next_answer);
        zone_answer_q.push_back(next_answer);
      end
      if (drain_done_i && !leftover_seen) begin
        leftover_seen = 1'b1;
        if (zone_answer_q.size() != 0)
          report_mismatch($sformatf("%0d predicted answers never arrived",
                                    zone_answer_q.size()));
      end
    end
    pending_o = zone_answer_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the zone allocator bench. It only makes stimulus and gives the
// verdict; all prediction and comparison happens in the answer checker that
// sits beside the block and watches every channel.
module tb;
  import zba_pkg::*;

  // The item kind that the block must treat as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Length of the deliberate result hold-off, in clock cycles.
  localparam int HOLD_CYCLES = 400;
  // Wait beyond the longest allocate scan at the end.
  localparam int LATENCY_TAIL = 270;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        kind = KIND_ALLOC;
  logic [ZONE_W-1:0] zone = '0;
  logic [7:0]        word_index = '0;
  logic [15:0]       word_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ZONE_W-1:0] result_zone;
  logic [1:0]        status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_FIRST_DATA_ZONE;
  logic [ZONE_W-1:0] cfg_data = '0;
  logic              drain_done = 1'b0;

  int fail_count;
  int pending;
  int answers;
  int no_space;

  // Bookkeeping for the stimulus side and the summary.
  int items_sent = 0;
  int settings_used = 0;
  int burst_left = 0;
  int holds_done = 0;
  int hold_count = 0;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  zone_bitmap_allocator_core uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .zone_i       (zone),
    .word_index_i (word_index),
    .word_data_i  (word_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .result_zone_o(result_zone),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  zba_answer_checker answer_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .kind_i       (kind),
    .zone_i       (zone),
    .word_index_i (word_index),
    .word_data_i  (word_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .result_zone_i(result_zone),
    .status_i     (status),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .drain_done_i (drain_done),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .answers_o    (answers),
    .no_space_o   (no_space)
  );

  // Idle lengths: random, with now and then a long pause.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 2);
    if (r < 88) return $urandom_range(3, 8);
    if (r < 97) return $urandom_range(9, 30);
    return $urandom_range(40, 100);
  endfunction

  // Gap after an accepted word. Bursts of back-to-back words are mixed in so
  // that the block also sees long stretches with no idling on the input.
  function automatic int next_send_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    return pick_idle_len();
  endfunction

  // Offers one word at a falling edge and holds it until a rising edge sees
  // valid high with stall low. Valid stays high when the next word follows
  // without a gap, so it is never dropped and raised within one time step.
  task automatic send_word(input logic [1:0] k, input logic [ZONE_W-1:0] z,
                           input logic [7:0] wi, input logic [15:0] wd);
    int gap;
    @(negedge clk);
    in_valid   <= 1'b1;
    kind       <= k;
    zone       <= z;
    word_index <= wi;
    word_data  <= wd;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = next_send_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops valid and waits until every predicted answer has come back. Every
  // item answers exactly once, so at that point the block holds no work.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ZONE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Picks a bit number inside the map, mostly among the first few words so
  // that loads, allocations and frees keep running into each other.
  function automatic int pick_bit(input longint msize);
    longint span;
    if (msize <= 0) return $urandom_range(0, 31);
    span = (msize > 96) ? 96 : msize;
    if ($urandom_range(0, 99) < 70) return $urandom_range(0, int'(span) - 1);
    return $urandom_range(0, int'(msize) - 1);
  endfunction

  // One random word. Most allocations and frees aim at zones inside the map;
  // the rest are raw 20-bit values and the edges of the valid range.
  task automatic send_random_item(input logic [ZONE_W-1:0] fdz, input logic [ZONE_W-1:0] zc,
                                  input longint msize);
    int                r, q;
    logic [1:0]        k;
    logic [ZONE_W-1:0] z;
    logic [7:0]        wi;
    logic [15:0]       wd;
    z  = ZONE_W'($urandom);
    wi = 8'($urandom);
    wd = 16'($urandom);
    r  = $urandom_range(0, 99);
    q  = $urandom_range(0, 99);
    if (r < 38) begin
      k = KIND_ALLOC;
      if (q < 35) begin
        z = fdz;
      end else if (q < 75) begin
        z = ZONE_W'(longint'(fdz) - 1 + pick_bit(msize));
      end else if (q >= 90) begin
        case ($urandom_range(0, 4))
          0:       z = fdz - 1'b1;
          1:       z = zc;
          2:       z = ZONE_W'(longint'(fdz) - 1 + msize);
          3:       z = '0;
          default: z = '1;
        endcase
      end
    end else if (r < 68) begin
      k = KIND_FREE;
      if (q < 65) begin
        z = ZONE_W'(longint'(fdz) - 1 + pick_bit(msize));
      end else if (q >= 85) begin
        case ($urandom_range(0, 4))
          0:       z = fdz - 1'b1;
          1:       z = zc;
          2:       z = zc - 1'b1;
          3:       z = ZONE_W'(longint'(fdz) - 1 + CAPACITY);
          default: z = '0;
        endcase
      end
    end else if (r < 92) begin
      k = KIND_LOAD;
      if (q < 75) wi = 8'(pick_bit(msize) / WORD_BITS);
      case ($urandom_range(0, 3))
        0:       wd = '1;
        1:       wd = 16'hFFFF ^ (16'd1 << $urandom_range(0, WORD_BITS - 1));
        2:       wd = '0;
        default: begin
        end
      endcase
    end else begin
      k = KIND_UNUSED;
    end
    send_word(k, z, wi, wd);
  endtask

  // One register setting followed by a run of random words. With_hold asks
  // the result side for one long hold-off early in the run, so the block
  // backs up and stalls its input while words keep being offered.
  task automatic run_phase(input logic [ZONE_W-1:0] fdz, input logic [ZONE_W-1:0] zc,
                           input int n_items, input bit with_hold);
    longint msize;
    wait_idle();
    write_reg(CFG_FIRST_DATA_ZONE, fdz);
    write_reg(CFG_ZONE_COUNT, zc);
    settings_used++;
    msize = longint'(zc) - longint'(fdz) + 1;
    if (msize < 0) msize = 0;
    if (msize > CAPACITY) msize = CAPACITY;
    for (int n = 0; n < n_items; n++) begin
      if (with_hold && n == 10) hold_req = 1'b1;
      send_random_item(fdz, zc, msize);
    end
  endtask

  // Result side: random stall runs and long stretches with no stall at all.
  // A hold-off request overrides that with a stall counted out here.
  initial begin
    int   r;
    int   len;
    logic level;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES - 1) begin
          @(negedge clk);
          hold_count++;
        end
        hold_req = 1'b0;
        holds_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          level = 1'b1;
          len   = pick_idle_len();
        end else if (r < 90) begin
          level = 1'b0;
          len   = $urandom_range(1, 8);
        end else begin
          level = 1'b0;
          len   = $urandom_range(40, 150);
        end
        out_stall <= level;
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Directed words under the reset setting: full 4096-bit map, base zone 1.
    // Allocation through the hint, from zone 0, and from an origin out of range.
    send_word(KIND_ALLOC, ZONE_W'(1), 8'h00, 16'h0000);
    send_word(KIND_ALLOC, ZONE_W'(0), 8'hFF, 16'hFFFF);
    send_word(KIND_ALLOC, '1, 8'h00, 16'h0000);
    send_word(KIND_ALLOC, ZONE_W'(2000), 8'h5A, 16'hA5A5);
    // Free it, free it again (already unused), then frees outside the range.
    send_word(KIND_FREE, ZONE_W'(2000), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(2000), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(0), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(4096), 8'h00, 16'h0000);
    send_word(KIND_FREE, '1, 8'hFF, 16'hFFFF);
    // A full last word forces the scan to wrap around to word zero.
    send_word(KIND_LOAD, ZONE_W'(0), 8'hFF, 16'hFFFF);
    send_word(KIND_ALLOC, ZONE_W'(4081), 8'h00, 16'h0000);
    // Fill word zero and most of word one, then follow the hint up and back down.
    send_word(KIND_LOAD, ZONE_W'(0), 8'h00, 16'hFFFF);
    send_word(KIND_LOAD, ZONE_W'(0), 8'h01, 16'h7FFF);
    send_word(KIND_ALLOC, ZONE_W'(1), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(5), 8'h00, 16'h0000);
    send_word(KIND_ALLOC, ZONE_W'(1), 8'h00, 16'h0000);
    send_word(KIND_UNUSED, ZONE_W'($urandom), 8'($urandom), 16'($urandom));
    send_word(KIND_LOAD, '1, 8'hAA, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(4095), 8'h00, 16'h0000);

    // A 20-bit map: the lowest clear bit of word one lies past the end, so
    // that word yields nothing and the whole circle ends with no space.
    wait_idle();
    write_reg(CFG_FIRST_DATA_ZONE, ZONE_W'(1));
    write_reg(CFG_ZONE_COUNT, ZONE_W'(20));
    settings_used++;
    send_word(KIND_LOAD, ZONE_W'(0), 8'h00, 16'hFFFF);
    send_word(KIND_LOAD, ZONE_W'(0), 8'h01, 16'h000F);
    send_word(KIND_ALLOC, ZONE_W'(1), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(19), 8'h00, 16'h0000);
    send_word(KIND_FREE, ZONE_W'(20), 8'h00, 16'h0000);
    send_word(KIND_ALLOC, ZONE_W'(1), 8'h00, 16'h0000);

    // Random part, across a spread of register settings including both ends
    // of each register, a base zone of zero and an empty map.
    run_phase(ZONE_W'(1), ZONE_W'(4096), 170, 1'b1);
    run_phase(ZONE_W'(1), '1, 110, 1'b0);
    run_phase(ZONE_W'(0), ZONE_W'(300), 110, 1'b0);
    run_phase(ZONE_W'(100), ZONE_W'(163), 110, 1'b1);
    run_phase(ZONE_W'(1048000), '1, 100, 1'b0);
    run_phase('1, '1, 70, 1'b0);
    run_phase(ZONE_W'(5000), ZONE_W'(10), 60, 1'b0);
    run_phase(ZONE_W'(0), ZONE_W'(0), 50, 1'b0);
    for (int p = 0; p < 2; p++) begin
      logic [ZONE_W-1:0] fdz;
      fdz = ZONE_W'($urandom_range(1, 2000));
      run_phase(fdz, fdz + ZONE_W'($urandom_range(0, 600)), 80, 1'b0);
    end

    // Drain, then give any stray answer time to show up before the verdict.
    wait_idle();
    repeat (LATENCY_TAIL) @(negedge clk);
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Run covered %0d words under %0d register settings, with %0d result hold-offs.",
             items_sent, settings_used, holds_done);
    $display("Checked %0d answers, %0d of them reporting no space.", answers, no_space);
    if (fail_count == 0) begin
      $display("** zone_bitmap_allocator_core: PASSED **");
    end else begin
      $display("** zone_bitmap_allocator_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, covering a hung handshake.
  initial begin
    #20000000;
    $display("Timed out with %0d answers still pending.", pending);
    $display("** zone_bitmap_allocator_core: FAILED **");
    $finish;
  end

endmodule
